@@ sv/rpr_pkg.sv @@
package rpr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int FIU_W      = 5;
  localparam int LFSR_W     = 16;
  localparam int MOD_CNT_W  = $clog2(LFSR_W);
  localparam int SLOT_OUT_W = 4;
  localparam int COUNT_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_IN_USE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_RANDOM_SEED   = CFG_ADDR_W'(1);

  localparam logic [FIU_W-1:0]  FIU_RESET  = FIU_W'(16);
  localparam logic [LFSR_W-1:0] SEED_RESET = LFSR_W'(44257);

  typedef struct packed {
    logic in_ready;
    logic load;
    logic scan_step;
    logic hit;
    logic miss;
    logic fill;
    logic evict_begin;
    logic mod_step;
    logic ev_read;
    logic evict;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic match;
    logic scan_end;
    logic can_fill;
    logic mod_last;
    logic out_free;
  } st_t;

  // x^16+x^14+x^13+x^11+1, Fibonacci, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

endpackage

@@ sv/rpr_in_if.sv @@
interface rpr_in_if
  import rpr_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

@@ sv/rpr_out_if.sv @@
interface rpr_out_if
  import rpr_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] frame_slot;
  logic                  evicted;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [COUNT_W-1:0]    hit_count;
  logic [COUNT_W-1:0]    miss_count;

  modport source (output valid, output hit, output frame_slot, output evicted,
                  output evicted_page, output hit_count, output miss_count,
                  input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted,
                  input evicted_page, input hit_count, input miss_count,
                  output ready);
endinterface

@@ sv/rpr_cfg_if.sv @@
interface rpr_cfg_if
  import rpr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ sv/random_page_replacement.sv @@
// Random page replacement over a fully associative frame table.
// Channels (valid/ready, a word moves when both are high):
//   cfg_ch : register writes, addr 0 = frames_in_use, addr 1 = random_seed.
//            Always ready; write only while the block is idle.
//   in_ch  : one page reference per word.
//   out_ch : one result word per reference (hit, slot, eviction, counters).
// One reference is worked on at a time. The table is scanned from a single
// read port, one slot a cycle over the filled slots. From acceptance to the
// result being offered, the steps are:
//   hit in slot k          : scan slots 0 to k
//   miss, free slot left   : scan the filled slots, then fill the next slot
//   miss, table full       : scan the filled slots, then the LFSR remainder
//                            loop, then read and rewrite of the victim
// The next reference can be taken as soon as the result is offered.
// The result sits in an output register; the block takes the next reference
// while it waits, and only holds a new result back until out_ch is free.
// Reset empties the table, clears both counters, sets frames_in_use to 16
// and loads the LFSR with 44257. No clearing pass is needed.
module random_page_replacement
  import rpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  rpr_cfg_if.sink     cfg_ch,
  rpr_in_if.sink      in_ch,
  rpr_out_if.source   out_ch
);

  cmd_t cmd;
  st_t  st;

  rpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  rpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .st     (st),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ sv/rpr_ctrl.sv @@
module rpr_ctrl
  import rpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  st_t  st,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    MOD,
    EV_RD,
    EV_WR,
    DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = SCAN;
        end
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.match) begin
          cmd.hit   = 1'b1;
          state_nxt = DONE;
        end else if (st.scan_end) begin
          cmd.miss = 1'b1;
          if (st.can_fill) begin
            cmd.fill  = 1'b1;
            state_nxt = DONE;
          end else begin
            cmd.evict_begin = 1'b1;
            state_nxt       = MOD;
          end
        end
      end
      MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) state_nxt = EV_RD;
      end
      EV_RD: begin
        cmd.ev_read = 1'b1;
        state_nxt   = EV_WR;
      end
      EV_WR: begin
        cmd.evict = 1'b1;
        state_nxt = DONE;
      end
      DONE: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/rpr_datapath.sv @@
module rpr_datapath
  import rpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output st_t               st,
  rpr_cfg_if.sink           cfg_ch,
  rpr_in_if.sink            in_ch,
  rpr_out_if.source         out_ch
);

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = (CNT_W > FIU_W) ? CNT_W : FIU_W;

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_r;

  logic [FIU_W-1:0]     fiu_r;
  logic [LFSR_W-1:0]    lfsr_r;
  logic [CNT_W-1:0]     filled_r;
  logic [COUNT_W-1:0]   hits_r;
  logic [COUNT_W-1:0]   misses_r;

  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     scan_idx_r;
  logic                 cmp_vld_r;
  logic [SLOT_W-1:0]    cmp_idx_r;

  logic [LFSR_W-1:0]    quo_r;
  logic [FIU_W-1:0]     rem_r;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  logic                 res_hit_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 res_ev_r;
  logic [PAGE_BITS-1:0] res_evpage_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_ev_r;
  logic [PAGE_BITS-1:0]  out_evpage_r;
  logic [COUNT_W-1:0]    out_hits_r;
  logic [COUNT_W-1:0]    out_misses_r;

  logic [FIU_W-1:0]      n_eff;
  logic                  scan_more;
  logic [SLOT_W-1:0]     victim;
  logic [FIU_W:0]        trial;
  logic [LFSR_W-1:0]     lfsr_adv;
  logic                  mem_we;
  logic                  mem_re;
  logic [SLOT_W-1:0]     wr_addr;
  logic [SLOT_W-1:0]     rd_addr;

  // zero counts as one frame, anything above the table size saturates
  always_comb begin
    if (fiu_r == '0) begin
      n_eff = FIU_W'(1);
    end else if (32'(fiu_r) > FRAMES) begin
      n_eff = FIU_W'(FRAMES);
    end else begin
      n_eff = fiu_r;
    end
  end

  assign scan_more = scan_idx_r < filled_r;
  assign victim    = SLOT_W'(rem_r);
  assign trial     = {rem_r, quo_r[LFSR_W-1]};
  assign lfsr_adv  = lfsr_next(lfsr_r);

  // slots fill in order, so a slot is valid exactly when below the fill count
  assign st.in_valid = in_ch.valid;
  assign st.match    = cmp_vld_r && (rd_data_r == page_r);
  assign st.scan_end = !cmp_vld_r && !scan_more;
  assign st.can_fill = CMP_W'(filled_r) < CMP_W'(n_eff);
  assign st.mod_last = mod_cnt_r == MOD_CNT_W'(LFSR_W - 1);
  assign st.out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  assign mem_we  = cmd.fill || cmd.evict;
  assign wr_addr = cmd.fill ? filled_r[SLOT_W-1:0] : victim;
  assign mem_re  = cmd.ev_read || (cmd.scan_step && scan_more);
  assign rd_addr = cmd.ev_read ? victim : scan_idx_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= page_r;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r       <= FIU_RESET;
      lfsr_r      <= SEED_RESET;
      filled_r    <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.addr)
          CFG_FRAMES_IN_USE: fiu_r <= cfg_ch.data[FIU_W-1:0];
          CFG_RANDOM_SEED: begin
            lfsr_r <= (cfg_ch.data[LFSR_W-1:0] == '0) ? LFSR_W'(1)
                                                       : cfg_ch.data[LFSR_W-1:0];
          end
          default: ;
        endcase
      end else if (cmd.evict_begin) begin
        lfsr_r <= lfsr_adv;
      end

      if (cmd.load) begin
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= scan_more;
      end

      if (cmd.fill) filled_r <= filled_r + CNT_W'(1);

      if (cmd.hit && hits_r != '1) hits_r <= hits_r + COUNT_W'(1);
      if (cmd.miss && misses_r != '1) misses_r <= misses_r + COUNT_W'(1);

      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r     <= in_ch.page_number;
      scan_idx_r <= '0;
    end else if (cmd.scan_step && scan_more) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
      cmp_idx_r  <= scan_idx_r[SLOT_W-1:0];
    end

    if (cmd.hit) begin
      res_hit_r    <= 1'b1;
      res_slot_r   <= cmp_idx_r;
      res_ev_r     <= 1'b0;
      res_evpage_r <= '0;
    end
    if (cmd.fill) begin
      res_hit_r    <= 1'b0;
      res_slot_r   <= filled_r[SLOT_W-1:0];
      res_ev_r     <= 1'b0;
      res_evpage_r <= '0;
    end
    if (cmd.evict) begin
      res_hit_r    <= 1'b0;
      res_slot_r   <= victim;
      res_ev_r     <= 1'b1;
      res_evpage_r <= rd_data_r;
    end

    // restoring remainder, one dividend bit per cycle
    if (cmd.evict_begin) begin
      quo_r     <= lfsr_adv;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      quo_r     <= {quo_r[LFSR_W-2:0], 1'b0};
      mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
      if (trial >= {1'b0, n_eff}) begin
        rem_r <= FIU_W'(trial - {1'b0, n_eff});
      end else begin
        rem_r <= FIU_W'(trial);
      end
    end

    if (cmd.publish) begin
      out_hit_r    <= res_hit_r;
      out_slot_r   <= SLOT_OUT_W'(res_slot_r);
      out_ev_r     <= res_ev_r;
      out_evpage_r <= res_evpage_r;
      out_hits_r   <= hits_r;
      out_misses_r <= misses_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.frame_slot   = out_slot_r;
  assign out_ch.evicted      = out_ev_r;
  assign out_ch.evicted_page = out_evpage_r;
  assign out_ch.hit_count    = out_hits_r;
  assign out_ch.miss_count   = out_misses_r;

endmodule
